@@ src/hcbp_pkg.sv @@
// Shared types and constants for the Huffman code bit packer.
// No dependencies; used by every module of the block.
package hcbp_pkg;

    localparam int MAX_CODE_BITS  = 32;
    localparam int CODE_WORD_BITS = 32;
    localparam int CODE_LIMIT     = (MAX_CODE_BITS < CODE_WORD_BITS) ? MAX_CODE_BITS
                                                                     : CODE_WORD_BITS;
    localparam int BYTE_BITS      = 8;
    localparam int NUM_SYMBOLS    = 256;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_ENCODE = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;

    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_PACK,
        ST_FLUSH_DATA,
        ST_FLUSH_COUNT
    } pack_state_t;

    typedef struct packed {
        logic [CODE_WORD_BITS-1:0] code;
        logic [5:0]                len;
    } code_entry_t;

    typedef struct packed {
        logic                 kind;
        logic [BYTE_BITS-1:0] value;
        logic                 last;
    } out_item_t;

endpackage

@@ src/huffman_code_bit_packer_top.sv @@
// Huffman code bit packer: code table memory, packing sequencer, output register.
// Depends on hcbp_pkg, hcbp_code_mem, hcbp_packer, hcbp_out_stage.
//
// The block takes one item at a time. A load item writes the symbol's code and
// length into the table in its accept cycle. An encode item is accepted, its
// code is read from the table, and then it is packed in steps, where each step
// fills at most one byte; an unloaded symbol packs nothing. A flush item with
// nothing pending sends nothing, else it sends the partial byte and then its
// bit count. The result channel carries one byte per cycle unless stalled.
module huffman_code_bit_packer_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  symbol,
    input  logic [31:0] code_word,
    input  logic [5:0]  code_length,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [7:0]  value,
    output logic        last_of_run
);

    logic                  mem_wr_en;
    logic                  mem_rd_en;
    logic [7:0]            mem_addr;
    hcbp_pkg::code_entry_t mem_wr_data;
    hcbp_pkg::code_entry_t mem_rd_data;
    logic                  item_valid;
    hcbp_pkg::out_item_t   item;
    logic                  item_stall;

    hcbp_code_mem u_code_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mem_wr_en),
        .rd_en   (mem_rd_en),
        .addr    (mem_addr),
        .wr_data (mem_wr_data),
        .rd_data (mem_rd_data)
    );

    hcbp_packer u_packer
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .symbol      (symbol),
        .code_word   (code_word),
        .code_length (code_length),
        .mem_wr_en   (mem_wr_en),
        .mem_rd_en   (mem_rd_en),
        .mem_addr    (mem_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_data (mem_rd_data),
        .item_valid  (item_valid),
        .item        (item),
        .item_stall  (item_stall)
    );

    hcbp_out_stage u_out_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item        (item),
        .item_stall  (item_stall),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .value       (value),
        .last_of_run (last_of_run)
    );

endmodule

@@ src/hcbp_code_mem.sv @@
// Code table: 256 code words and code lengths in synchronous memories.
// Length entries carry valid bits so an unloaded symbol reads as length zero.
// Depends on hcbp_pkg.
module hcbp_code_mem
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  wr_en,
    input  logic                                  rd_en,
    input  logic [7:0]                            addr,
    input  hcbp_pkg::code_entry_t                 wr_data,
    output hcbp_pkg::code_entry_t                 rd_data
);

    logic [hcbp_pkg::CODE_WORD_BITS-1:0] code_mem [hcbp_pkg::NUM_SYMBOLS];
    logic [5:0]                          len_mem  [hcbp_pkg::NUM_SYMBOLS];
    logic [hcbp_pkg::NUM_SYMBOLS-1:0]    valid_reg;

    logic [hcbp_pkg::CODE_WORD_BITS-1:0] code_rd_reg;
    logic [5:0]                          len_rd_reg;
    logic                                vld_rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            code_mem[addr] <= wr_data.code;
            len_mem[addr]  <= wr_data.len;
        end
        if (rd_en)
        begin
            code_rd_reg <= code_mem[addr];
            len_rd_reg  <= len_mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            vld_rd_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[addr] <= 1'b1;
            end
            if (rd_en)
            begin
                vld_rd_reg <= valid_reg[addr];
            end
        end
    end

    always_comb
    begin
        rd_data.code = code_rd_reg;
        rd_data.len  = vld_rd_reg ? len_rd_reg : 6'd0;
    end

endmodule

@@ src/hcbp_packer.sv @@
// Command sequencer and bit packer: looks up codes, merges them into the
// partial byte one step per cycle unless stalled, and hands finished items
// onward. Depends on hcbp_pkg; drives hcbp_code_mem.
module hcbp_packer
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            cmd,
    input  logic [7:0]            symbol,
    input  logic [31:0]           code_word,
    input  logic [5:0]            code_length,
    output logic                  mem_wr_en,
    output logic                  mem_rd_en,
    output logic [7:0]            mem_addr,
    output hcbp_pkg::code_entry_t mem_wr_data,
    input  hcbp_pkg::code_entry_t mem_rd_data,
    output logic                  item_valid,
    output hcbp_pkg::out_item_t   item,
    input  logic                  item_stall
);

    hcbp_pkg::pack_state_t state_reg, state_next;

    logic [7:0]  pb_reg,   pb_next;
    logic [2:0]  fill_reg, fill_next;
    logic [31:0] code_reg, code_next;
    logic [5:0]  left_reg, left_next;

    logic        accept;
    logic [3:0]  room;
    logic [3:0]  step_n;
    logic [3:0]  fill_sum;
    logic [7:0]  mask;
    logic [7:0]  merged;
    logic [5:0]  left_after;
    logic        step_full;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != hcbp_pkg::ST_IDLE);

    // One packing step: take as many leading code bits as fit in the byte.
    always_comb
    begin
        room       = 4'd8 - {1'b0, fill_reg};
        step_n     = ({2'b00, room} > left_reg) ? left_reg[3:0] : room;
        fill_sum   = {1'b0, fill_reg} + step_n;
        mask       = (8'hFF >> fill_reg) & ~(8'hFF >> fill_sum);
        merged     = (pb_reg & ~mask) | ((code_reg[31:24] >> fill_reg) & mask);
        left_after = left_reg - {2'b00, step_n};
        step_full  = (fill_sum == 4'd8);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hcbp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == hcbp_pkg::CMD_ENCODE)
                    begin
                        state_next = hcbp_pkg::ST_LOOKUP;
                    end
                    else if (cmd == hcbp_pkg::CMD_FLUSH && fill_reg != 3'd0)
                    begin
                        state_next = hcbp_pkg::ST_FLUSH_DATA;
                    end
                end
            end
            hcbp_pkg::ST_LOOKUP:
            begin
                state_next = (mem_rd_data.len == 6'd0) ? hcbp_pkg::ST_IDLE
                                                       : hcbp_pkg::ST_PACK;
            end
            hcbp_pkg::ST_PACK:
            begin
                if (!(step_full && item_stall) && left_after == 6'd0)
                begin
                    state_next = hcbp_pkg::ST_IDLE;
                end
            end
            hcbp_pkg::ST_FLUSH_DATA:
            begin
                if (!item_stall)
                begin
                    state_next = hcbp_pkg::ST_FLUSH_COUNT;
                end
            end
            hcbp_pkg::ST_FLUSH_COUNT:
            begin
                if (!item_stall)
                begin
                    state_next = hcbp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hcbp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pb_next          = pb_reg;
        fill_next        = fill_reg;
        code_next        = code_reg;
        left_next        = left_reg;
        mem_wr_en        = 1'b0;
        mem_rd_en        = 1'b0;
        mem_addr         = symbol;
        mem_wr_data.code = code_word;
        mem_wr_data.len  = (code_length > 6'(hcbp_pkg::CODE_LIMIT))
                           ? 6'(hcbp_pkg::CODE_LIMIT) : code_length;
        item_valid       = 1'b0;
        item.kind        = hcbp_pkg::KIND_DATA;
        item.value       = merged;
        item.last        = 1'b0;
        unique case (state_reg)
            hcbp_pkg::ST_IDLE:
            begin
                mem_wr_en = accept && (cmd == hcbp_pkg::CMD_LOAD);
                mem_rd_en = accept && (cmd == hcbp_pkg::CMD_ENCODE);
            end
            hcbp_pkg::ST_LOOKUP:
            begin
                // left-align the code so its first bit sits at the MSB
                code_next = mem_rd_data.code << (6'd32 - mem_rd_data.len);
                left_next = mem_rd_data.len;
            end
            hcbp_pkg::ST_PACK:
            begin
                item_valid = step_full;
                item.value = merged;
                item.last  = (left_after < 6'd8);
                if (!(step_full && item_stall))
                begin
                    pb_next   = merged;
                    fill_next = fill_sum[2:0];
                    left_next = left_after;
                    code_next = code_reg << step_n;
                end
            end
            hcbp_pkg::ST_FLUSH_DATA:
            begin
                item_valid = 1'b1;
                item.value = pb_reg;
            end
            hcbp_pkg::ST_FLUSH_COUNT:
            begin
                item_valid = 1'b1;
                item.kind  = hcbp_pkg::KIND_COUNT;
                item.value = {5'd0, fill_reg};
                item.last  = 1'b1;
                if (!item_stall)
                begin
                    fill_next = 3'd0;
                end
            end
            default:
            begin
                item_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hcbp_pkg::ST_IDLE;
            pb_reg    <= 8'd0;
            fill_reg  <= 3'd0;
            left_reg  <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            pb_reg    <= pb_next;
            fill_reg  <= fill_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
    end

endmodule

@@ src/hcbp_out_stage.sv @@
// Output register between the packer and the result channel.
// Depends on hcbp_pkg.
module hcbp_out_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  hcbp_pkg::out_item_t item,
    output logic                item_stall,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                kind,
    output logic [7:0]          value,
    output logic                last_of_run
);

    logic                out_valid_reg, out_valid_next;
    hcbp_pkg::out_item_t item_reg;
    logic                load;

    assign item_stall = out_valid_reg && out_stall;
    assign load       = item_valid && !item_stall;

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = item_reg.kind;
    assign value       = item_reg.value;
    assign last_of_run = item_reg.last;

endmodule
